/* design/vn_pkg.sv */
// Shared widths and types of the vector normalization pipeline.
package vn_pkg;
   localparam int CW     = 32;          // component width
   localparam int FB     = 30;          // fraction bits of a unit component
   localparam int SQW    = 2 * CW;      // square and sum of squares width
   localparam int QW     = FB + 1;      // unsigned quotient width
   localparam int UW     = FB + 2;      // signed unit component width
   localparam int LANES  = 3;

   typedef struct packed {
      logic [LANES-1:0][CW-1:0] mag;
      logic [LANES-1:0]         neg;
   } side_type;
endpackage

/* design/vn_if.sv */
// Valid/ready channel interfaces for vector items and normalized results.
interface vn_req_if import vn_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] comp_x;
   logic signed [CW-1:0] comp_y;
   logic signed [CW-1:0] comp_z;
   modport source (output valid, comp_x, comp_y, comp_z, input ready);
   modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

interface vn_rsp_if import vn_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic        [CW-1:0] length;
   logic signed [UW-1:0] unit_x;
   logic signed [UW-1:0] unit_y;
   logic signed [UW-1:0] unit_z;
   logic                 zero_length;
   modport source (output valid, length, unit_x, unit_y, unit_z, zero_length, input ready);
   modport sink   (input valid, length, unit_x, unit_y, unit_z, zero_length, output ready);
endinterface

/* design/vn_square.sv */
// One lane's sign split and squaring stage.
module vn_square import vn_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [CW-1:0] comp,
   output logic        [CW-1:0] mag,
   output logic                 neg,
   output logic       [SQW-1:0] sq
);
   logic [CW-1:0] mag_in;

   // The most negative value maps to 2^(CW-1), which still fits unsigned.
   assign mag_in = comp[CW-1] ? (CW'(0) - CW'(comp)) : CW'(comp);

   always_ff @(posedge clock) begin
      if (en) begin
         mag <= mag_in;
         neg <= comp[CW-1];
         sq  <= SQW'(mag_in) * SQW'(mag_in);
      end
   end
endmodule

/* design/vn_sqrt.sv */
// Pipelined digit-by-digit square root, one root bit per stage.
module vn_sqrt import vn_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [SQW-1:0] radicand,
   input  side_type       in_side,
   output logic           out_valid,
   output logic [CW-1:0]  root,
   output side_type       out_side
);
   logic [CW:0]    rem_c  [0:CW];
   logic [CW-1:0]  root_c [0:CW];
   logic [SQW-1:0] rad_c  [0:CW];
   side_type       side_c [0:CW];
   logic           vld_c  [0:CW];

   logic [CW:0]    rem_ff  [1:CW];
   logic [CW-1:0]  root_ff [1:CW];
   logic [SQW-1:0] rad_ff  [1:CW];
   side_type       side_ff [1:CW];
   logic           vld_ff  [1:CW];

   logic [CW:0]    rem_in  [0:CW-1];
   logic [CW-1:0]  root_in [0:CW-1];

   always_comb begin
      rem_c[0]  = '0;
      root_c[0] = '0;
      rad_c[0]  = radicand;
      side_c[0] = in_side;
      vld_c[0]  = in_valid;
      for (int i = 1; i <= CW; i++) begin
         rem_c[i]  = rem_ff[i];
         root_c[i] = root_ff[i];
         rad_c[i]  = rad_ff[i];
         side_c[i] = side_ff[i];
         vld_c[i]  = vld_ff[i];
      end
   end

   always_comb begin
      logic [CW+2:0] t;
      logic [CW+2:0] trial;
      for (int i = 0; i < CW; i++) begin
         t     = {rem_c[i], rad_c[i][SQW-1 -: 2]};
         trial = {1'b0, root_c[i], 2'b01};
         if (t >= trial) begin
            rem_in[i]  = (CW+1)'(t - trial);
            root_in[i] = {root_c[i][CW-2:0], 1'b1};
         end else begin
            rem_in[i]  = t[CW:0];
            root_in[i] = {root_c[i][CW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CW; i++) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_c[i];
         end
         if (en) begin
            rem_ff[i+1]  <= rem_in[i];
            root_ff[i+1] <= root_in[i];
            rad_ff[i+1]  <= rad_c[i] << 2;
            side_ff[i+1] <= side_c[i];
         end
      end
   end

   assign out_valid = vld_ff[CW];
   assign root      = root_ff[CW];
   assign out_side  = side_ff[CW];
endmodule

/* design/vn_div.sv */
// One lane's pipelined restoring divider of (a << FB) by d, one quotient bit per stage.
module vn_div import vn_pkg::*; (
   input  logic          clock,
   input  logic          en,
   input  logic [CW-1:0] dividend,
   input  logic [CW-1:0] divisor,
   input  logic          in_neg,
   output logic [QW-1:0] quotient,
   output logic [CW-1:0] divisor_out,
   output logic          out_neg
);
   logic [CW-1:0] rem_c [0:QW];
   logic [QW-1:0] quo_c [0:QW];
   logic [CW-1:0] d_c   [0:QW];
   logic          neg_c [0:QW];

   logic [CW-1:0] rem_ff [1:QW];
   logic [QW-1:0] quo_ff [1:QW];
   logic [CW-1:0] d_ff   [1:QW];
   logic          neg_ff [1:QW];

   logic [CW-1:0] rem_in [0:QW-1];
   logic          bit_in [0:QW-1];

   always_comb begin
      // The dividend never reaches twice the divisor, so its top part starts below it.
      rem_c[0] = dividend >> 1;
      quo_c[0] = '0;
      d_c[0]   = divisor;
      neg_c[0] = in_neg;
      for (int i = 1; i <= QW; i++) begin
         rem_c[i] = rem_ff[i];
         quo_c[i] = quo_ff[i];
         d_c[i]   = d_ff[i];
         neg_c[i] = neg_ff[i];
      end
   end

   always_comb begin
      logic [CW:0] t;
      for (int i = 0; i < QW; i++) begin
         t = {rem_c[i], (i == 0) ? dividend[0] : 1'b0};
         if (t >= {1'b0, d_c[i]}) begin
            rem_in[i] = CW'(t - {1'b0, d_c[i]});
            bit_in[i] = 1'b1;
         end else begin
            rem_in[i] = t[CW-1:0];
            bit_in[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QW; i++) begin
         if (en) begin
            rem_ff[i+1] <= rem_in[i];
            quo_ff[i+1] <= {quo_c[i][QW-2:0], bit_in[i]};
            d_ff[i+1]   <= d_c[i];
            neg_ff[i+1] <= neg_c[i];
         end
      end
   end

   assign quotient    = quo_ff[QW];
   assign divisor_out = d_ff[QW];
   assign out_neg     = neg_ff[QW];
endmodule

/* design/vector3_normalize.sv */
// Throughput: one vector per cycle; the whole pipeline advances while the output
// register is empty or being taken, and holds as one otherwise.
// Reset clears every stage's valid bit; data registers are not reset.
// Stages: three squaring lanes, sum, square-root stages, three divider lanes, merge.
module vector3_normalize import vn_pkg::*; (
   input logic        clock,
   input logic        reset,
   vn_req_if.sink     req,
   vn_rsp_if.source   rsp
);
   logic                     en;
   logic                     v1_ff, v2_ff;
   logic [LANES-1:0][CW-1:0] mag;
   logic [LANES-1:0]         neg;
   logic [LANES-1:0][SQW-1:0] sq;
   logic [SQW-1:0]           sum_ff;
   side_type                 side_ff;
   logic                     sq_valid;
   logic [CW-1:0]            root;
   side_type                 root_side;
   logic [LANES-1:0][QW-1:0] quo;
   logic [LANES-1:0][CW-1:0] dout;
   logic [LANES-1:0]         qneg;
   logic                     dv_ff [1:QW];
   logic [LANES-1:0][UW-1:0] unit_in;
   logic                     zero_in;
   logic                     out_valid_ff;
   logic [CW-1:0]            length_ff;
   logic [LANES-1:0][UW-1:0] unit_ff;
   logic                     zero_ff;

   assign en        = !out_valid_ff || rsp.ready;
   assign req.ready = en;

   vn_square u_sq_x (.clock, .en, .comp(req.comp_x), .mag(mag[0]), .neg(neg[0]), .sq(sq[0]));
   vn_square u_sq_y (.clock, .en, .comp(req.comp_y), .mag(mag[1]), .neg(neg[1]), .sq(sq[1]));
   vn_square u_sq_z (.clock, .en, .comp(req.comp_z), .mag(mag[2]), .neg(neg[2]), .sq(sq[2]));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
      end
      if (en) begin
         sum_ff      <= sq[0] + sq[1] + sq[2];
         side_ff.mag <= mag;
         side_ff.neg <= neg;
      end
   end

   vn_sqrt u_sqrt (
      .clock, .reset, .en,
      .in_valid(v2_ff), .radicand(sum_ff), .in_side(side_ff),
      .out_valid(sq_valid), .root, .out_side(root_side)
   );

   for (genvar l = 0; l < LANES; l++) begin : g_div
      vn_div u_div (
         .clock, .en,
         .dividend(root_side.mag[l]), .divisor(root), .in_neg(root_side.neg[l]),
         .quotient(quo[l]), .divisor_out(dout[l]), .out_neg(qneg[l])
      );
   end

   always_ff @(posedge clock) begin
      for (int i = 1; i <= QW; i++) begin
         if (reset) begin
            dv_ff[i] <= 1'b0;
         end else if (en) begin
            dv_ff[i] <= (i == 1) ? sq_valid : dv_ff[i-1 < 1 ? 1 : i-1];
         end
      end
   end

   // Merge: apply signs and force zeros for a zero-length vector.
   always_comb begin
      zero_in = (dout[0] == '0);
      for (int l = 0; l < LANES; l++) begin
         if (zero_in) begin
            unit_in[l] = '0;
         end else if (qneg[l]) begin
            unit_in[l] = UW'(0) - UW'(quo[l]);
         end else begin
            unit_in[l] = UW'(quo[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dv_ff[QW];
      end
      if (en) begin
         length_ff <= dout[0];
         unit_ff   <= unit_in;
         zero_ff   <= zero_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.length      = length_ff;
   assign rsp.unit_x      = unit_ff[0];
   assign rsp.unit_y      = unit_ff[1];
   assign rsp.unit_z      = unit_ff[2];
   assign rsp.zero_length = zero_ff;

   a_zero_clean: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.zero_length |->
         rsp.length == '0 && rsp.unit_x == '0 && rsp.unit_y == '0 && rsp.unit_z == '0)
      else $error("zero-length result carries nonzero fields");

   a_flag_match: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.zero_length |-> rsp.length != '0)
      else $error("nonzero result with zero length");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |->
         $signed(rsp.unit_x) <= $signed(UW'(1) << FB) &&
         $signed(rsp.unit_x) >= -$signed(UW'(1) << FB))
      else $error("unit component out of range");
endmodule

/* tb/testbench.sv */
// Self-checking testbench for the vector normalization pipeline.
module testbench import vn_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [CW-1:0] x, y, z;
   } vector_type;

   typedef struct {
      logic [CW-1:0]        length;
      logic signed [UW-1:0] ux, uy, uz;
      logic                 zero;
   } unit_result_type;

   localparam int LATENCY = CW + FB + 3;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   vn_req_if req ();
   vn_rsp_if rsp ();

   vector3_normalize uut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   vector_type      pending_vectors[$];
   unit_result_type expected_units[$];
   int     send_idle_pct;
   int     recv_idle_pct;
   int     hold_off_cycles;
   bit     sender_paused;
   int     errors;
   int     results_seen;
   int     zero_seen;
   longint cycle_count;

   // Magnitude of a two's complement component; the most negative value is exact.
   function automatic logic [CW-1:0] comp_magnitude(logic signed [CW-1:0] c);
      return c[CW-1] ? (~c + 1'b1) : c;
   endfunction

   function automatic logic [CW-1:0] isqrt_floor(logic [SQW+1:0] s);
      logic [CW:0]      root;
      logic [CW:0]      trial;
      root = '0;
      for (int b = CW; b >= 0; b--) begin
         trial = root | ((CW+1)'(1) << b);
         if ({(SQW+2)'(trial) * (SQW+2)'(trial)} <= s) root = trial;
      end
      return root[CW-1:0];
   endfunction

   function automatic logic signed [UW-1:0] unit_component(logic signed [CW-1:0] c,
                                                          logic [CW-1:0] len);
      logic [CW+FB-1:0] q;
      q = ({{FB{1'b0}}, comp_magnitude(c)} << FB) / (CW+FB)'(len);
      return c[CW-1] ? UW'(-q) : UW'(q);
   endfunction

   function automatic unit_result_type normalize(vector_type v);
      unit_result_type r;
      logic [SQW+1:0]  sum;
      sum = (SQW+2)'(comp_magnitude(v.x)) * comp_magnitude(v.x)
          + (SQW+2)'(comp_magnitude(v.y)) * comp_magnitude(v.y)
          + (SQW+2)'(comp_magnitude(v.z)) * comp_magnitude(v.z);
      r.length = isqrt_floor(sum);
      r.zero   = (r.length == 0);
      if (r.zero) begin
         r.ux = '0; r.uy = '0; r.uz = '0;
      end else begin
         r.ux = unit_component(v.x, r.length);
         r.uy = unit_component(v.y, r.length);
         r.uz = unit_component(v.z, r.length);
      end
      return r;
   endfunction

   function automatic logic signed [CW-1:0] random_comp();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 3) == 0 ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
         1: return CW'($signed($urandom_range(0, 64)) - 32);
         2: return CW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return $urandom;
      endcase
   endfunction

   task automatic add_vector(logic signed [CW-1:0] x, y, z);
      vector_type v;
      v.x = x; v.y = y; v.z = z;
      pending_vectors.push_back(v);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Driver: offers the head of the pending queue, idling at random.
   // An offered transfer stays unchanged until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            expected_units.push_back(normalize(pending_vectors.pop_front()));
         end
         if (req.valid && !req.ready) begin
            req.valid <= 1'b1;
         end else if (pending_vectors.size() > 0 && !sender_paused
                      && ($urandom_range(0, 99) >= send_idle_pct)) begin
            req.valid  <= 1'b1;
            req.comp_x <= pending_vectors[0].x;
            req.comp_y <= pending_vectors[0].y;
            req.comp_z <= pending_vectors[0].z;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each result transfer and drives ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_units.size() == 0) begin
               $error("unexpected result transfer, length %0h", rsp.length);
               errors++;
            end else begin
               unit_result_type e;
               e = expected_units.pop_front();
               results_seen++;
               if (e.zero) zero_seen++;
               if (rsp.length !== e.length) begin
                  $error("length: expected %0h, got %0h", e.length, rsp.length); errors++;
               end
               if (rsp.unit_x !== e.ux) begin
                  $error("unit_x: expected %0h, got %0h", e.ux, rsp.unit_x); errors++;
               end
               if (rsp.unit_y !== e.uy) begin
                  $error("unit_y: expected %0h, got %0h", e.uy, rsp.unit_y); errors++;
               end
               if (rsp.unit_z !== e.uz) begin
                  $error("unit_z: expected %0h, got %0h", e.uz, rsp.unit_z); errors++;
               end
               if (rsp.zero_length !== e.zero) begin
                  $error("zero_length: expected %0b, got %0b", e.zero, rsp.zero_length);
                  errors++;
               end
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_vectors.size() != 0 || req.valid || expected_units.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      logic signed [CW-1:0] most_neg, most_pos;
      int                   n;
      most_neg = {1'b1, {(CW-1){1'b0}}};
      most_pos = {1'b0, {(CW-1){1'b1}}};
      req.valid = 1'b0; req.comp_x = '0; req.comp_y = '0; req.comp_z = '0;
      rsp.ready = 1'b0;
      errors = 0; results_seen = 0; zero_seen = 0; cycle_count = 0;
      hold_off_cycles = 0; sender_paused = 1'b0;
      send_idle_pct = 12; recv_idle_pct = 74;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero vector, extremes, most negative values, axes, tiny values.
      add_vector(0, 0, 0);
      add_vector(most_neg, most_neg, most_neg);
      add_vector(most_pos, most_pos, most_pos);
      add_vector(most_neg, 0, 0);
      add_vector(0, most_neg, 0);
      add_vector(0, 0, most_neg);
      add_vector(most_pos, 0, 0);
      add_vector(0, most_pos, 0);
      add_vector(0, 0, most_pos);
      add_vector(1, 0, 0);
      add_vector(0, -1, 0);
      add_vector(0, 0, 1);
      add_vector(1, 1, 1);
      add_vector(-1, -1, -1);
      add_vector(32'h0001_0000, 32'h0001_0000, 0);
      add_vector(3, 4, 0);
      add_vector(-32'sh0003_0000, 32'sh0004_0000, -32'sh000c_0000);
      add_vector(most_neg, most_pos, 1);
      add_vector(-1, 0, 0);
      add_vector(32'h5555_5555, -32'sh5555_5556, 32'h2aaa_aaaa);
      wait_drained();

      // Random: sender idles rarely, receiver often.
      repeat (220) add_vector(random_comp(), random_comp(), random_comp());
      // Long receiver stall while the sender keeps offering, so the pipeline backs up.
      hold_off_cycles <= 300;
      wait_drained();

      send_idle_pct = 74; recv_idle_pct = 12;
      repeat (210) add_vector(random_comp(), random_comp(), random_comp());
      repeat (100) @(posedge clock);
      // Sender pauses with items still pending until every expected result has come.
      sender_paused = 1'b1;
      while (req.valid || expected_units.size() != 0) @(posedge clock);
      sender_paused = 1'b0;
      wait_drained();

      send_idle_pct = 0; recv_idle_pct = 0;
      for (n = 0; n < 200; n++) begin
         if (n % 25 == 0) add_vector(0, 0, 0);
         else add_vector(random_comp(), random_comp(), random_comp());
      end
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);

      $display("Checked %0d normalized vectors, %0d of them zero length, under three",
               results_seen, zero_seen);
      $display("idle mixes plus a long output stall and a sender pause.");
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
